// ----- src/haversine_cone_filter_assert.svh -----
// ----------------------------------------------------------------------------
// haversine cone filter assertion macros
// Concurrent assertion wrappers, empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef HAVERSINE_CONE_FILTER_ASSERT_SVH
`define HAVERSINE_CONE_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define HCF_ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hcf assertion failed");
`define HCF_ASSERT(lbl, prop) `HCF_ASSERT_CLK(lbl, i_clk, i_rst_n, prop)
`else
`define HCF_ASSERT_CLK(lbl, clk, rst_n, prop)
`define HCF_ASSERT(lbl, prop)
`endif
`endif

// ----- src/hcf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcf_pkg
// Types, fixed-point constants and the cordic arctangent table.
// ----------------------------------------------------------------------------
package hcf_pkg;

    // field widths and formats
    localparam int FRAC_BITS   = 16;
    localparam int ENTRY_LIMIT = 65536;
    localparam int HALF_SHIFT  = 31 - FRAC_BITS;
    localparam int FULL_SHIFT  = 32 - FRAC_BITS;

    localparam int ZW   = 44;
    localparam int XW   = 34;
    localparam int AW   = 36;
    localparam int SQW  = 62;

    localparam int STEPS      = 30;
    localparam int SQ_STEPS   = 31;
    localparam int CORDIC_LAT = STEPS + 2;
    localparam int MUL_LAT    = 3;
    localparam int PIPE_LAT   = CORDIC_LAT + MUL_LAT + SQ_STEPS + STEPS;

    typedef logic [15:0]          t_index;
    typedef logic [24:0]          t_ra;
    typedef logic signed [23:0]   t_dec;
    typedef logic [23:0]          t_sep;
    typedef logic [1:0]           t_reg_idx;
    typedef logic [24:0]          t_reg_data;
    typedef logic signed [ZW-1:0] t_angle;
    typedef logic signed [XW-1:0] t_trig;
    typedef logic signed [AW-1:0] t_axy;
    typedef logic [30:0]          t_root;
    typedef logic [60:0]          t_aval;

    typedef struct packed {
        t_index idx;
        t_sep   sep;
    } t_match;

    // register indexes
    localparam t_reg_idx REG_CENTER_RA  = 2'd0;
    localparam t_reg_idx REG_CENTER_DEC = 2'd1;
    localparam t_reg_idx REG_RADIUS     = 2'd2;

    // angles in q32 degrees
    localparam t_angle FULL_TURN    = 44'sd1546188226560;
    localparam t_angle HALF_TURN    = 44'sd773094113280;
    localparam t_angle QUARTER_TURN = 44'sd386547056640;

    localparam t_trig GAIN_Q30 = 34'sd652032874;
    localparam t_aval A_ONE    = t_aval'(64'd1 << 60);

    localparam logic [63:0] FIVE_POW12 = 64'd244140625;
    localparam logic [63:0] PD_PER_RAD = 64'd57295779513082;

    // atan(2^-step) in q32 degrees, from picodegree values
    function automatic t_angle atan_q32(input int step);
        logic [63:0] pd;
        logic [63:0] q;
        logic [63:0] r;
        case (step)
            0: pd = 64'd45000000000000;
            1: pd = 64'd26565051177078;
            2: pd = 64'd14036243467926;
            3: pd = 64'd7125016348902;
            4: pd = 64'd3576334374997;
            5: pd = 64'd1789910608246;
            6: pd = 64'd895173710211;
            7: pd = 64'd447614170861;
            8: pd = 64'd223810500369;
            default: pd = PD_PER_RAD >> step;
        endcase
        q = pd / FIVE_POW12;
        r = pd % FIVE_POW12;
        return t_angle'((q << 20) + ((r << 20) + FIVE_POW12 / 2) / FIVE_POW12);
    endfunction

endpackage

// ----- src/hcf_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcf channel interfaces
// Entry, match and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hcf_entry_if;
    logic            valid;
    logic            ready;
    hcf_pkg::t_index entry_index;
    hcf_pkg::t_ra    entry_ra;
    hcf_pkg::t_dec   entry_dec;
    modport source(output valid, entry_index, entry_ra, entry_dec, input ready);
    modport sink(input valid, entry_index, entry_ra, entry_dec, output ready);
endinterface

interface hcf_match_if;
    logic            valid;
    logic            ready;
    hcf_pkg::t_index match_index;
    hcf_pkg::t_sep   separation;
    modport source(output valid, match_index, separation, input ready);
    modport sink(input valid, match_index, separation, output ready);
endinterface

interface hcf_cfg_if;
    logic               valid;
    logic               ready;
    hcf_pkg::t_reg_idx  wr_index;
    hcf_pkg::t_reg_data wr_data;
    modport source(output valid, wr_index, wr_data, input ready);
    modport sink(input valid, wr_index, wr_data, output ready);
endinterface

// ----- src/hcf_sincos.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcf_sincos
// Pipelined rotation cordic: range reduction, one stage per step, sign fix.
// ----------------------------------------------------------------------------
module hcf_sincos (
    input  logic            i_clk,
    input  logic            i_en,
    input  hcf_pkg::t_angle i_theta,
    output hcf_pkg::t_trig  o_cos,
    output hcf_pkg::t_trig  o_sin
);

    hcf_pkg::t_trig  r_x   [0:hcf_pkg::STEPS];
    hcf_pkg::t_trig  r_y   [0:hcf_pkg::STEPS];
    logic            r_neg [0:hcf_pkg::STEPS];
    hcf_pkg::t_angle r_z   [0:hcf_pkg::STEPS-1];
    hcf_pkg::t_trig  r_cos;
    hcf_pkg::t_trig  r_sin;
    hcf_pkg::t_angle n_z0;
    logic            n_neg0;
    hcf_pkg::t_angle w_wrap;

    // reduce to [-180, 180) then fold into [-90, 90]
    always_comb begin
        if (i_theta >= hcf_pkg::HALF_TURN) begin
            w_wrap = i_theta - hcf_pkg::FULL_TURN;
        end else if (i_theta < -hcf_pkg::HALF_TURN) begin
            w_wrap = i_theta + hcf_pkg::FULL_TURN;
        end else begin
            w_wrap = i_theta;
        end
        if (w_wrap > hcf_pkg::QUARTER_TURN) begin
            n_z0   = w_wrap - hcf_pkg::HALF_TURN;
            n_neg0 = 1'b1;
        end else if (w_wrap < -hcf_pkg::QUARTER_TURN) begin
            n_z0   = w_wrap + hcf_pkg::HALF_TURN;
            n_neg0 = 1'b1;
        end else begin
            n_z0   = w_wrap;
            n_neg0 = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= hcf_pkg::GAIN_Q30;
            r_y[0]   <= '0;
            r_z[0]   <= n_z0;
            r_neg[0] <= n_neg0;
        end
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < hcf_pkg::STEPS; i++) begin : g_step
        localparam hcf_pkg::t_angle ATAN_I = hcf_pkg::atan_q32(i);
        hcf_pkg::t_trig  n_x;
        hcf_pkg::t_trig  n_y;
        hcf_pkg::t_angle n_z;

        always_comb begin
            if (!r_z[i][hcf_pkg::ZW-1]) begin
                n_x = r_x[i] - (r_y[i] >>> i);
                n_y = r_y[i] + (r_x[i] >>> i);
                n_z = r_z[i] - ATAN_I;
            end else begin
                n_x = r_x[i] + (r_y[i] >>> i);
                n_y = r_y[i] - (r_x[i] >>> i);
                n_z = r_z[i] + ATAN_I;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i+1]   <= n_x;
                r_y[i+1]   <= n_y;
                r_neg[i+1] <= r_neg[i];
            end
        end

        if (i < hcf_pkg::STEPS - 1) begin : g_z
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_z[i+1] <= n_z;
                end
            end
        end
    end

    // restore quadrant
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= r_neg[hcf_pkg::STEPS] ? -r_x[hcf_pkg::STEPS] : r_x[hcf_pkg::STEPS];
            r_sin <= r_neg[hcf_pkg::STEPS] ? -r_y[hcf_pkg::STEPS] : r_y[hcf_pkg::STEPS];
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

// ----- src/hcf_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcf_sqrt
// Pipelined bitwise integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module hcf_sqrt (
    input  logic           i_clk,
    input  logic           i_en,
    input  hcf_pkg::t_aval i_val,
    output hcf_pkg::t_root o_root
);

    localparam int LAST = hcf_pkg::SQ_STEPS - 1;

    logic [hcf_pkg::SQW-1:0] w_v   [0:LAST];
    logic [hcf_pkg::SQW-1:0] w_res [0:LAST];
    logic [hcf_pkg::SQW-1:0] r_v   [0:LAST-1];
    logic [hcf_pkg::SQW-1:0] r_res [0:LAST];

    for (genvar k = 0; k <= LAST; k++) begin : g_stage
        localparam logic [hcf_pkg::SQW-1:0] BIT_K = hcf_pkg::SQW'(1) << (60 - 2 * k);
        logic [hcf_pkg::SQW-1:0] w_trial;
        logic                    w_ge;
        logic [hcf_pkg::SQW-1:0] n_res;

        // stage inputs
        if (k == 0) begin : g_first
            assign w_v[k]   = {1'b0, i_val};
            assign w_res[k] = '0;
        end else begin : g_next
            assign w_v[k]   = r_v[k-1];
            assign w_res[k] = r_res[k-1];
        end

        // trial subtract
        assign w_trial = w_res[k] + BIT_K;
        assign w_ge    = (w_v[k] >= w_trial);
        assign n_res   = w_ge ? ((w_res[k] >> 1) + BIT_K) : (w_res[k] >> 1);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_res[k] <= n_res;
            end
        end

        if (k < LAST) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_v[k] <= w_ge ? (w_v[k] - w_trial) : w_v[k];
                end
            end
        end
    end

    assign o_root = r_res[LAST][30:0];

endmodule

// ----- src/hcf_atan2.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcf_atan2
// Pipelined vectoring cordic giving atan2(y, x) in q32 degrees.
// ----------------------------------------------------------------------------
module hcf_atan2 (
    input  logic            i_clk,
    input  logic            i_en,
    input  hcf_pkg::t_root  i_x,
    input  hcf_pkg::t_root  i_y,
    output hcf_pkg::t_angle o_angle
);

    localparam int LAST = hcf_pkg::STEPS - 1;

    hcf_pkg::t_axy   w_x [0:LAST];
    hcf_pkg::t_axy   w_y [0:LAST];
    hcf_pkg::t_angle w_z [0:LAST];
    hcf_pkg::t_axy   r_x [0:LAST-1];
    hcf_pkg::t_axy   r_y [0:LAST-1];
    hcf_pkg::t_angle r_z [0:LAST];

    for (genvar i = 0; i <= LAST; i++) begin : g_step
        localparam hcf_pkg::t_angle ATAN_I = hcf_pkg::atan_q32(i);
        hcf_pkg::t_axy   n_x;
        hcf_pkg::t_axy   n_y;
        hcf_pkg::t_angle n_z;

        // stage inputs
        if (i == 0) begin : g_first
            assign w_x[i] = hcf_pkg::t_axy'({1'b0, i_x});
            assign w_y[i] = hcf_pkg::t_axy'({1'b0, i_y});
            assign w_z[i] = '0;
        end else begin : g_next
            assign w_x[i] = r_x[i-1];
            assign w_y[i] = r_y[i-1];
            assign w_z[i] = r_z[i-1];
        end

        // rotate toward the x axis
        always_comb begin
            if (w_y[i] > 0) begin
                n_x = w_x[i] + (w_y[i] >>> i);
                n_y = w_y[i] - (w_x[i] >>> i);
                n_z = w_z[i] + ATAN_I;
            end else begin
                n_x = w_x[i] - (w_y[i] >>> i);
                n_y = w_y[i] + (w_x[i] >>> i);
                n_z = w_z[i] - ATAN_I;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_z[i] <= n_z;
            end
        end

        if (i < LAST) begin : g_xy
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[i] <= n_x;
                    r_y[i] <= n_y;
                end
            end
        end
    end

    assign o_angle = r_z[LAST];

endmodule

// ----- src/haversine_cone_filter.sv -----
// throughput: one entry per cycle while the skid stage is empty;
// 30-step cordic and 31-step root pipelines set the depth
// a full output register plus a taken skid stage stalls the whole pipeline
// until the output transfers
// reset: synchronous active low; clears all valid bits and the three registers to zero
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haversine_cone_filter
// Streams catalog entries, computes haversine separation to the cone centre
// and emits index and separation for entries inside the radius.
// ----------------------------------------------------------------------------
`include "haversine_cone_filter_assert.svh"
module haversine_cone_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hcf_entry_if.sink   i_entry,
    hcf_match_if.source o_match,
    hcf_cfg_if.sink     i_cfg
);

    localparam int L      = hcf_pkg::PIPE_LAT;
    localparam int ZSUM_W = hcf_pkg::ZW + 2;

    // configuration registers
    hcf_pkg::t_ra  r_center_ra;
    hcf_pkg::t_dec r_center_dec;
    logic [23:0]   r_radius;

    // pipeline control
    logic            w_en;
    logic            r_vld [0:L];
    hcf_pkg::t_index r_idx [0:L];

    // input stage
    logic signed [25:0] w_edec, w_cdec, w_rad, w_lo, w_hi, w_ddec, w_era, w_cra, w_dra;
    logic               w_band_ok, w_idx_ok;
    hcf_pkg::t_angle    r_th_s1, r_th_s2, r_th_c1, r_th_c2;

    // trig and products
    hcf_pkg::t_trig     w_s1, w_s2, w_c1, w_c2;
    logic signed [67:0] w_p_ss, w_p_cc, w_p_s2, w_p_cs;
    logic signed [63:0] r_s1sq, r_s1sq_d, r_prod, w_a;
    hcf_pkg::t_trig     r_cc, r_s2sq;
    hcf_pkg::t_aval     r_ay, r_ax, w_ac;
    hcf_pkg::t_root     w_ry, w_rx;

    // final stage
    hcf_pkg::t_angle    w_z, w_zc;
    logic [ZSUM_W-1:0]  w_sum;
    logic [29:0]        w_sep_full;
    logic               w_last;
    logic               w_out_free;
    logic               r_out_vld, r_skid_vld;
    hcf_pkg::t_match    r_out, r_skid, w_new;

    // register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_ra  <= '0;
            r_center_dec <= '0;
            r_radius     <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.wr_index)
                hcf_pkg::REG_CENTER_RA:  r_center_ra  <= i_cfg.wr_data;
                hcf_pkg::REG_CENTER_DEC: r_center_dec <= i_cfg.wr_data[23:0];
                hcf_pkg::REG_RADIUS:     r_radius     <= i_cfg.wr_data[23:0];
                default: ;
            endcase
        end
    end

    // pipeline advances unless the skid stage is occupied
    assign w_en          = !r_skid_vld;
    assign i_entry.ready = w_en;

    // declination band and index limit
    assign w_edec    = 26'(i_entry.entry_dec);
    assign w_cdec    = 26'(r_center_dec);
    assign w_rad     = {2'b00, r_radius};
    assign w_lo      = w_cdec - w_rad;
    assign w_hi      = w_cdec + w_rad;
    assign w_band_ok = !(w_edec < w_lo || w_edec > w_hi);
    assign w_idx_ok  = {9'b0, i_entry.entry_index} < 25'(hcf_pkg::ENTRY_LIMIT);

    // angle differences
    assign w_era  = {1'b0, i_entry.entry_ra};
    assign w_cra  = {1'b0, r_center_ra};
    assign w_ddec = w_edec - w_cdec;
    assign w_dra  = w_era - w_cra;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_th_s1 <= hcf_pkg::t_angle'(w_ddec) <<< hcf_pkg::HALF_SHIFT;
            r_th_s2 <= hcf_pkg::t_angle'(w_dra) <<< hcf_pkg::HALF_SHIFT;
            r_th_c1 <= hcf_pkg::t_angle'(w_cdec) <<< hcf_pkg::FULL_SHIFT;
            r_th_c2 <= hcf_pkg::t_angle'(w_edec) <<< hcf_pkg::FULL_SHIFT;
        end
    end

    // valid and index travel alongside the arithmetic
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= L; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_entry.valid && w_band_ok && w_idx_ok;
            for (int k = 1; k <= L; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_idx[0] <= i_entry.entry_index;
            for (int k = 1; k <= L; k++) begin
                r_idx[k] <= r_idx[k-1];
            end
        end
    end

    // four trig units
    hcf_sincos u_sin_dec (
        .i_clk(i_clk), .i_en(w_en), .i_theta(r_th_s1), .o_cos(), .o_sin(w_s1)
    );
    hcf_sincos u_sin_ra (
        .i_clk(i_clk), .i_en(w_en), .i_theta(r_th_s2), .o_cos(), .o_sin(w_s2)
    );
    hcf_sincos u_cos_cdec (
        .i_clk(i_clk), .i_en(w_en), .i_theta(r_th_c1), .o_cos(w_c1), .o_sin()
    );
    hcf_sincos u_cos_edec (
        .i_clk(i_clk), .i_en(w_en), .i_theta(r_th_c2), .o_cos(w_c2), .o_sin()
    );

    // first products
    assign w_p_ss = w_s1 * w_s1;
    assign w_p_cc = w_c1 * w_c2;
    assign w_p_s2 = w_s2 * w_s2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1sq <= w_p_ss[63:0];
            r_cc   <= w_p_cc[63:30];
            r_s2sq <= w_p_s2[63:30];
        end
    end

    // cosine product times sin^2 of half ra difference
    assign w_p_cs = r_cc * r_s2sq;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prod   <= w_p_cs[63:0];
            r_s1sq_d <= r_s1sq;
        end
    end

    // haversine term, clamped to [0, 1]
    assign w_a = r_s1sq_d + r_prod;

    always_comb begin
        if (w_a[63]) begin
            w_ac = '0;
        end else if (w_a[62:0] > {2'b00, hcf_pkg::A_ONE}) begin
            w_ac = hcf_pkg::A_ONE;
        end else begin
            w_ac = w_a[60:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ay <= w_ac;
            r_ax <= hcf_pkg::A_ONE - w_ac;
        end
    end

    hcf_sqrt u_sqrt_y (.i_clk(i_clk), .i_en(w_en), .i_val(r_ay), .o_root(w_ry));
    hcf_sqrt u_sqrt_x (.i_clk(i_clk), .i_en(w_en), .i_val(r_ax), .o_root(w_rx));

    hcf_atan2 u_atan2 (
        .i_clk(i_clk), .i_en(w_en), .i_x(w_rx), .i_y(w_ry), .o_angle(w_z)
    );

    // double, round to output scale, compare with radius
    assign w_zc       = w_z[hcf_pkg::ZW-1] ? '0 : w_z;
    assign w_sum      = {1'b0, w_zc, 1'b0} + (ZSUM_W'(1) << hcf_pkg::HALF_SHIFT);
    assign w_sep_full = w_sum[hcf_pkg::FULL_SHIFT +: 30];
    assign w_last     = r_vld[L] && (w_sep_full <= {6'b0, r_radius});
    assign w_new.idx  = r_idx[L];
    assign w_new.sep  = w_sep_full[23:0];

    // output register with skid stage
    assign w_out_free = !r_out_vld || o_match.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= w_en && w_last;
            end
        end else if (w_en && w_last) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out <= r_skid_vld ? r_skid : w_new;
        end else if (w_en && w_last) begin
            r_skid <= w_new;
        end
    end

    assign o_match.valid       = r_out_vld;
    assign o_match.match_index = r_out.idx;
    assign o_match.separation  = r_out.sep;

    // checks
    `HCF_ASSERT(a_skid_needs_out, r_skid_vld |-> r_out_vld)
    `HCF_ASSERT(a_stall_holds_last, (!w_en && r_vld[L]) |=> r_vld[L])
    `HCF_ASSERT(a_out_in_radius, r_out_vld |-> (r_out.sep <= r_radius))
    `HCF_ASSERT(a_skid_in_radius, r_skid_vld |-> (r_skid.sep <= r_radius))

endmodule

// ----- verif/haversine_cone_filter_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haversine_cone_filter_checker
// Watches the register, entry and match channels, predicts the cone matches
// with a fixed-point haversine model and compares every match transfer.
// ----------------------------------------------------------------------------
module haversine_cone_filter_checker
    import hcf_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    hcf_entry_if   entry_ch,
    hcf_match_if   match_ch,
    hcf_cfg_if     cfg_ch,
    output int     o_errors,
    output int     o_pending
);

    localparam longint Q30_ONE  = 64'sd1 << 30;
    localparam longint DEG_UNIT = 64'sd1 << 32;

    // shadow copy of the cone registers
    t_ra    cone_ra;
    t_dec   cone_dec;
    t_sep   cone_radius;

    t_match expected_matches[$];
    longint arc_step[STEPS];

    // atan(2^-i) in q32 degrees from picodegree values
    initial begin
        longint unsigned pd;
        longint unsigned q;
        longint unsigned r;
        longint unsigned pd_small[9];
        pd_small = '{64'd45000000000000, 64'd26565051177078, 64'd14036243467926,
                     64'd7125016348902, 64'd3576334374997, 64'd1789910608246,
                     64'd895173710211, 64'd447614170861, 64'd223810500369};
        for (int i = 0; i < STEPS; i++) begin
            pd = (i < 9) ? pd_small[i] : (64'd57295779513082 >> i);
            q  = pd / 64'd244140625;
            r  = pd % 64'd244140625;
            arc_step[i] = longint'((q << 20) + ((r << 20) + 64'd122070312) / 64'd244140625);
        end
    end

    // rotation-mode cordic, cos and sin in q30 of a q32-degree angle
    function automatic void rotate_angle(input longint theta, output longint c,
                                         output longint s);
        longint full;
        longint half;
        longint quarter;
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        full    = 360 * DEG_UNIT;
        half    = 180 * DEG_UNIT;
        quarter = 90 * DEG_UNIT;
        z = theta % full;
        x = 652032874;
        y = 0;
        flip = 0;
        if (z < 0) z += full;
        if (z >= half) z -= full;
        if (z > quarter) begin
            z -= half;
            flip = 1;
        end else if (z < -quarter) begin
            z += half;
            flip = 1;
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= arc_step[i];
            end else begin
                x += dx; y -= dy; z += arc_step[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // vectoring-mode cordic, angle of (x, y) in q32 degrees
    function automatic longint vector_angle(input longint x, input longint y);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += arc_step[i];
            end else begin
                x -= dx; y += dy; z -= arc_step[i];
            end
        end
        return (z < 0) ? 0 : z;
    endfunction

    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v  -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // haversine separation and cone decision for one entry
    function automatic bit cone_hit(input t_ra era_in, input t_dec edec_in,
                                    output t_sep sep_out);
        longint era;
        longint edec;
        longint cra;
        longint cdec;
        longint rad;
        longint hu;
        longint c1;
        longint c2;
        longint s1;
        longint s2;
        longint unused;
        longint cc;
        longint s2sq;
        longint a;
        longint unsigned ry;
        longint unsigned rx;
        longint d;
        longint unsigned sep;
        era  = longint'(era_in);
        edec = longint'(edec_in);
        cra  = longint'(cone_ra);
        cdec = longint'(cone_dec);
        rad  = longint'(cone_radius);
        hu   = 64'sd1 << (31 - FRAC_BITS);
        sep_out = '0;
        if (edec < cdec - rad || edec > cdec + rad) return 0;
        rotate_angle((edec - cdec) * hu, unused, s1);
        rotate_angle((era - cra) * hu, unused, s2);
        rotate_angle(cdec * hu * 2, c1, unused);
        rotate_angle(edec * hu * 2, c2, unused);
        cc   = (c1 * c2) >>> 30;
        s2sq = (s2 * s2) >>> 30;
        a = s1 * s1 + cc * s2sq;
        if (a < 0) a = 0;
        if (a > Q30_ONE * Q30_ONE) a = Q30_ONE * Q30_ONE;
        ry = floor_root(a);
        rx = floor_root(Q30_ONE * Q30_ONE - a);
        d  = 2 * vector_angle(longint'(rx), longint'(ry));
        sep = (longint'(d) + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
        if (sep > rad) return 0;
        sep_out = t_sep'(sep);
        return 1;
    endfunction

    // track register writes, predict on entry transfers, compare matches
    always @(posedge i_clk) begin
        t_sep   sep;
        t_match got;
        t_match want;
        t_match fresh;
        if (!i_rst_n) begin
            cone_ra     <= '0;
            cone_dec    <= '0;
            cone_radius <= '0;
            o_errors    <= 0;
            expected_matches.delete();
            o_pending   <= 0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.wr_index)
                    REG_CENTER_RA:  cone_ra     <= t_ra'(cfg_ch.wr_data);
                    REG_CENTER_DEC: cone_dec    <= t_dec'(cfg_ch.wr_data[23:0]);
                    REG_RADIUS:     cone_radius <= t_sep'(cfg_ch.wr_data[23:0]);
                    default: ;
                endcase
            end
            if (entry_ch.valid && entry_ch.ready) begin
                if (int'(entry_ch.entry_index) < ENTRY_LIMIT &&
                    cone_hit(entry_ch.entry_ra, entry_ch.entry_dec, sep)) begin
                    fresh = '{idx: entry_ch.entry_index, sep: sep};
                    expected_matches.insert(expected_matches.size(), fresh);
                end
            end
            if (match_ch.valid && match_ch.ready) begin
                got = '{idx: match_ch.match_index, sep: match_ch.separation};
                if (expected_matches.size() == 0) begin
                    $display("%0t: match expected none actual index %0d separation %0d",
                             $time, got.idx, got.sep);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_matches.pop_front();
                    if (got.idx !== want.idx) begin
                        $display("%0t: match_index expected %0d actual %0d",
                                 $time, want.idx, got.idx);
                        o_errors <= o_errors + 1;
                    end else if (got.sep !== want.sep) begin
                        $display("%0t: separation expected %0d actual %0d (index %0d)",
                                 $time, want.sep, got.sep, want.idx);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= expected_matches.size();
        end
    end

endmodule

// ----- verif/haversine_cone_filter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haversine_cone_filter_tb
// Drives cone settings and catalog entries with random stalls on both sides;
// the checker predicts matches and counts mismatches for the verdict.
// ----------------------------------------------------------------------------
module haversine_cone_filter_tb;
    import hcf_pkg::*;

    localparam int  STALL_LIMIT = 5000;
    localparam int  DRAIN_WAIT  = 120;
    localparam longint RA_SPAN  = 23592960;
    localparam longint DEC_MAX  = 5898240;
    localparam longint RAD_MAX  = 11796480;
    localparam longint DEG      = 65536;

    logic i_clk;
    logic i_rst_n;
    int   mismatches;
    int   outstanding;
    int   stall_cycles;
    int   hold_left;
    bit   steady;
    longint cur_ra;
    longint cur_dec;
    longint cur_rad;
    int   next_index;

    hcf_entry_if entry_ch();
    hcf_match_if match_ch();
    hcf_cfg_if   cfg_ch();

    haversine_cone_filter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (entry_ch),
        .o_match (match_ch),
        .i_cfg   (cfg_ch)
    );

    haversine_cone_filter_checker checker_i (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .entry_ch  (entry_ch),
        .match_ch  (match_ch),
        .cfg_ch    (cfg_ch),
        .o_errors  (mismatches),
        .o_pending (outstanding)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // match-side backpressure in bursts
    always @(negedge i_clk) begin
        if (steady || !i_rst_n) begin
            match_ch.ready <= 1'b1;
            hold_left <= 0;
        end else if (hold_left > 0) begin
            match_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            match_ch.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) hold_left <= $urandom_range(1, 13);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((entry_ch.valid && entry_ch.ready) || (match_ch.valid && match_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(input t_reg_idx idx, input longint value);
        cfg_ch.valid    <= 1'b1;
        cfg_ch.wr_index <= idx;
        cfg_ch.wr_data  <= t_reg_data'(value);
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // wait for the pipeline to empty before touching registers
    task automatic wait_drained();
        entry_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic set_cone(input longint ra, input longint dec, input longint rad);
        wait_drained();
        cur_ra  = ra & 32'h1FFFFFF;
        cur_dec = dec;
        cur_rad = rad & 32'hFFFFFF;
        write_reg(REG_CENTER_RA, cur_ra);
        write_reg(REG_CENTER_DEC, dec & 32'hFFFFFF);
        write_reg(REG_RADIUS, cur_rad);
        // unlisted index must be ignored
        if ($urandom_range(0, 1)) write_reg(t_reg_idx'(3), $urandom);
    endtask

    // one entry transfer, entered and left at a falling edge
    task automatic send_entry(input longint idx, input longint ra, input longint dec);
        int gap;
        if (!steady && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 13);
            entry_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        entry_ch.valid       <= 1'b1;
        entry_ch.entry_index <= t_index'(idx);
        entry_ch.entry_ra    <= t_ra'(ra);
        entry_ch.entry_dec   <= t_dec'(dec);
        do @(posedge i_clk); while (!entry_ch.ready);
        @(negedge i_clk);
    endtask

    // entry near the cone edge most of the time, else anywhere
    task automatic random_entry();
        longint span;
        longint ra;
        longint dec;
        int     pick;
        pick = $urandom_range(0, 99);
        span = cur_rad + cur_rad / 4 + 1;
        if (pick < 70) begin
            dec = cur_dec + longint'($urandom_range(0, 2 * span)) - span;
            ra  = cur_ra + longint'($urandom_range(0, 2 * span)) - span;
            ra  = ((ra % RA_SPAN) + RA_SPAN) % RA_SPAN;
            if (dec > DEC_MAX) dec = DEC_MAX;
            if (dec < -DEC_MAX) dec = -DEC_MAX;
        end else if (pick < 85) begin
            ra  = $urandom_range(0, RA_SPAN - 1);
            dec = longint'($urandom_range(0, 2 * DEC_MAX)) - DEC_MAX;
        end else begin
            ra  = $urandom & 32'h1FFFFFF;
            dec = longint'(t_dec'($urandom));
        end
        send_entry($urandom & 16'hFFFF, ra, dec);
    endtask

    function automatic longint pick_radius();
        case ($urandom_range(0, 4))
            0: return 0;
            1: return RAD_MAX;
            2: return $urandom_range(1, DEG);
            3: return $urandom_range(DEG, 30 * DEG);
            default: return $urandom_range(0, 24'hFFFFFF);
        endcase
    endfunction

    initial begin
        steady     = 1'b0;
        stall_cycles = 0;
        hold_left  = 0;
        next_index = 0;
        i_rst_n    = 1'b0;
        entry_ch.valid       = 1'b0;
        entry_ch.entry_index = '0;
        entry_ch.entry_ra    = '0;
        entry_ch.entry_dec   = '0;
        match_ch.ready       = 1'b1;
        cfg_ch.valid         = 1'b0;
        cfg_ch.wr_index      = REG_CENTER_RA;
        cfg_ch.wr_data       = '0;
        cur_ra = 0; cur_dec = 0; cur_rad = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset cone: zero radius, only the exact centre matches
        send_entry(0, 0, 0);
        send_entry(16'hFFFF, 1, 0);
        send_entry(1, 0, -1);

        // small cone off the equator
        set_cone(10 * DEG, 20 * DEG, 5 * DEG);
        send_entry(2, 10 * DEG, 20 * DEG);
        send_entry(3, 10 * DEG, 25 * DEG);
        send_entry(4, 10 * DEG, 25 * DEG + 1);
        send_entry(5, 10 * DEG, 15 * DEG - 1);
        send_entry(6, 14 * DEG, 22 * DEG);
        send_entry(7, 16 * DEG, 20 * DEG);
        send_entry(8, 32'h1FFFFFF, 20 * DEG);
        send_entry(9, 10 * DEG, -24'sd8388608);

        // cone across the ra wrap
        set_cone(RA_SPAN - 1, 0, 2 * DEG);
        send_entry(10, 0, 0);
        send_entry(11, RA_SPAN - 1, DEG);
        send_entry(12, DEG, -DEG);
        send_entry(13, RA_SPAN - 2 * DEG, 0);

        // widest cone from the north pole
        set_cone(0, DEC_MAX, RAD_MAX);
        send_entry(14, 0, -DEC_MAX);
        send_entry(15, 12345678, DEC_MAX);
        send_entry(16, 32'h1FFFFFF, 24'sh7FFFFF);
        send_entry(17, 90 * DEG, 0);

        // extreme register patterns
        set_cone(32'h1FFFFFF, -24'sd8388608, 24'hFFFFFF);
        send_entry(18, 0, -DEC_MAX);
        send_entry(19, 32'h1FFFFFF, 24'sh7FFFFF);

        // random phases, the last one without stalls
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 7)
                set_cone($urandom & 32'h1FFFFFF, longint'(t_dec'($urandom)), pick_radius());
            else
                set_cone($urandom_range(0, RA_SPAN - 1),
                         longint'($urandom_range(0, 2 * DEC_MAX)) - DEC_MAX, pick_radius());
            if (ph == 7) steady = 1'b1;
            for (int n = 0; n < 204; n++) random_entry();
        end

        entry_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        if (mismatches == 0 && outstanding == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/hcf_pkg.sv
src/hcf_if.sv
src/hcf_sincos.sv
src/hcf_sqrt.sv
src/hcf_atan2.sv
src/haversine_cone_filter.sv
verif/haversine_cone_filter_checker.sv
verif/haversine_cone_filter_tb.sv
